[hdl/aes_pkg.sv]
// ----------------------------------------------------------------------------
// aes_pkg: shared types, tables and round functions for the AES-128 block
// Holds the S-boxes, GF(2^8) helpers and the per-round transforms.
// ----------------------------------------------------------------------------
`default_nettype none
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned CfgAddrW  = 5;

  localparam logic [CfgAddrW-1:0] AddrKeyUpper   = 5'd0;
  localparam logic [CfgAddrW-1:0] AddrKeyLower   = 5'd8;
  localparam logic [CfgAddrW-1:0] AddrSwapEnable = 5'd16;

  typedef enum logic {
    ActEncrypt = 1'b0,
    ActDecrypt = 1'b1
  } action_e;

  // byte i of the block sits in bits [127-8i -: 8]
  typedef logic [127:0] block_t;

  // per-stage control travelling down the chain
  typedef struct packed {
    logic    valid;
    action_e action;
    logic    swap;
  } stage_ctl_t;

  function automatic logic [7:0] sbox_fwd(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] sbox_inv(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
      8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
      8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
      8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
      8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
      8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
      8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
      8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
      8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
      8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
      8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
      8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
      8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
      8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
      8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
    };
    return t[a];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd0: v = 8'h01;
      4'd1: v = 8'h02;
      4'd2: v = 8'h04;
      4'd3: v = 8'h08;
      4'd4: v = 8'h10;
      4'd5: v = 8'h20;
      4'd6: v = 8'h40;
      4'd7: v = 8'h80;
      4'd8: v = 8'h1b;
      4'd9: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gbyte(input block_t s, input int unsigned i);
    return s[127-8*i -: 8];
  endfunction

  function automatic block_t edge_swap(input block_t s);
    block_t t;
    t = s;
    t[127:120] = s[119:112];
    t[119:112] = s[127:120];
    t[15:8]    = s[7:0];
    t[7:0]     = s[15:8];
    return t;
  endfunction

  function automatic block_t sub_shift(input block_t s, input logic inv);
    block_t t;
    int unsigned src;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inv ? ((c - r + 4) & 3) : ((c + r) & 3);
        t[127-8*(4*c+r) -: 8] = inv ? sbox_inv(gbyte(s, 4*src+r))
                                    : sbox_fwd(gbyte(s, 4*src+r));
      end
    end
    return t;
  endfunction

  function automatic block_t mix(input block_t s, input logic inv);
    block_t t;
    logic [7:0] a [4];
    logic [7:0] x2, x4, x8;
    logic [7:0] m [4][4];
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        a[j] = gbyte(s, 4*c+j);
        x2 = xt(a[j]);
        x4 = xt(x2);
        x8 = xt(x4);
        // m[j][k]: a[j] times coefficient k of the row pattern
        if (inv) begin
          m[j][0] = x8 ^ x4 ^ x2;
          m[j][1] = x8 ^ x2 ^ a[j];
          m[j][2] = x8 ^ x4 ^ a[j];
          m[j][3] = x8 ^ a[j];
        end else begin
          m[j][0] = x2;
          m[j][1] = x2 ^ a[j];
          m[j][2] = a[j];
          m[j][3] = a[j];
        end
      end
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = m[0][(4-r)&3] ^ m[1][(5-r)&3]
                              ^ m[2][(6-r)&3] ^ m[3][(7-r)&3];
      end
    end
    return t;
  endfunction

  // next round key from the previous one; r counts from 0
  function automatic block_t key_next(input block_t k, input logic [3:0] r);
    logic [31:0] w [4];
    logic [31:0] g;
    block_t n;
    for (int i = 0; i < 4; i++) w[i] = k[127-32*i -: 32];
    g = {sbox_fwd(w[3][23:16]) ^ rcon(r), sbox_fwd(w[3][15:8]),
         sbox_fwd(w[3][7:0]), sbox_fwd(w[3][31:24])};
    w[0] = w[0] ^ g;
    w[1] = w[1] ^ w[0];
    w[2] = w[2] ^ w[1];
    w[3] = w[3] ^ w[2];
    n = {w[0], w[1], w[2], w[3]};
    return n;
  endfunction

endpackage
`default_nettype wire

[hdl/aes_stream_if.sv]
// ----------------------------------------------------------------------------
// aes_in_if / aes_out_if: valid/ready channels for blocks and results
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface aes_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [63:0] block_upper;
  logic [63:0] block_lower;
  modport source (output valid, action, block_upper, block_lower, input ready);
  modport sink   (input valid, action, block_upper, block_lower, output ready);
endinterface

interface aes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_upper;
  logic [63:0] result_lower;
  modport source (output valid, result_upper, result_lower, input ready);
  modport sink   (input valid, result_upper, result_lower, output ready);
endinterface
`default_nettype wire

[hdl/aes_cfg_regs.sv]
// ----------------------------------------------------------------------------
// aes_cfg_regs: APB register bank
// Key halves and swap enable, readable back.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_cfg_regs
  import aes_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [63:0]         pwdata,
  output logic      [63:0]         prdata,
  output logic                     pready,
  output block_t                   key_o,
  output logic                     swap_o
);
  logic [63:0] key_upper_q, key_lower_q;
  logic        swap_q;
  logic        wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_upper_q <= '0;
      key_lower_q <= '0;
      swap_q      <= 1'b1;
    end else if (wr) begin
      case (paddr)
        AddrKeyUpper:   key_upper_q <= pwdata;
        AddrKeyLower:   key_lower_q <= pwdata;
        AddrSwapEnable: swap_q      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      AddrKeyUpper:   prdata = key_upper_q;
      AddrKeyLower:   prdata = key_lower_q;
      AddrSwapEnable: prdata = {63'd0, swap_q};
      default:        prdata = '0;
    endcase
  end

  assign key_o  = {key_upper_q, key_lower_q};
  assign swap_o = swap_q;
endmodule
`default_nettype wire

[hdl/aes_key_cell.sv]
// ----------------------------------------------------------------------------
// aes_key_cell: one step of the round key chain
// Registers the next round key worked out from the previous cell's key.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_key_cell
  import aes_pkg::*;
#(
  parameter int unsigned Round = 0
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  block_t    key_i,
  output block_t    key_o
);
  block_t key_q, key_d;

  assign key_d = key_next(key_i, 4'(Round));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  assign key_o = key_q;
endmodule
`default_nettype wire

[hdl/aes_round_cell.sv]
// ----------------------------------------------------------------------------
// aes_round_cell: one registered round of the cipher chain
// Encrypt and decrypt share the cell; the direction travels with the block.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_round_cell
  import aes_pkg::*;
#(
  parameter int unsigned Round = 1
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   en_i,
  input  stage_ctl_t  ctl_i,
  input  block_t      data_i,
  input  block_t      key_enc_i,   // rk[Round]
  input  block_t      key_dec_i,   // rk[10-Round]
  output stage_ctl_t  ctl_o,
  output block_t      data_o
);
  localparam bit Last = (Round == NumRounds);

  stage_ctl_t ctl_q;
  block_t     data_q, data_d, ss;

  always_comb begin
    if (ctl_i.action == ActEncrypt) begin
      ss     = sub_shift(data_i, 1'b0);
      data_d = (Last ? ss : mix(ss, 1'b0)) ^ key_enc_i;
      if (Last && ctl_i.swap) data_d = edge_swap(data_d);
    end else begin
      ss     = sub_shift(data_i, 1'b1) ^ key_dec_i;
      data_d = Last ? ss : mix(ss, 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) data_q <= data_d;
  end

  assign ctl_o  = ctl_q;
  assign data_o = data_q;
endmodule
`default_nettype wire

[hdl/aes128_block_cipher_with_swap.sv]
// ----------------------------------------------------------------------------
// aes128_block_cipher_with_swap: pipelined AES-128 with edge byte swap
// Ten round cells in a chain, one block per cycle while in_if ready is high.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : block transactions (action, block_upper, block_lower).
//   out_if : result transactions (result_upper, result_lower).
//   APB    : key_upper at 0x00, key_lower at 0x08, swap_enable at 0x10.
//            64-bit data, pready tied high. Write only while idle.
// Pipeline: one entry stage (decrypt swap and initial key add) plus ten
//   round cells between accepted block and result valid.
// Throughput: one transaction per cycle while in_if ready is high; each
//   round cell holds one block and hands it on whenever the chain advances.
// Round keys come from a registered key chain off the key registers, one
//   round key per cell. After any register write, and after reset, in_if
//   ready stays low while the new keys ripple down the chain.
// Stall: the whole chain advances only when the output stage is empty or
//   taken, so ready follows the output side and nothing is dropped.
// Reset: key cleared, swap_enable set, pipeline emptied.
// ----------------------------------------------------------------------------
`default_nettype none
module aes128_block_cipher_with_swap
  import aes_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  aes_in_if.sink                   in_if,
  aes_out_if.source                out_if,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [63:0]         pwdata,
  output logic      [63:0]         prdata,
  output logic                     pready
);
  block_t rk [NumRounds+1];
  logic   swap;
  logic   adv;
  logic   cfg_wr;
  logic [3:0] settle_q, settle_d;

  stage_ctl_t ctl  [NumRounds+1];
  block_t     data [NumRounds+1];
  stage_ctl_t ctl0_q;
  block_t     data0_q, data0_d, blk;

  aes_cfg_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite,
    .paddr,
    .pwdata, .prdata, .pready,
    .key_o  (rk[0]),
    .swap_o (swap)
  );

  for (genvar r = 0; r < NumRounds; r++) begin : g_key
    aes_key_cell #(.Round(r)) u_key (
      .clk_i, .rst_ni, .key_i(rk[r]), .key_o(rk[r+1])
    );
  end

  // key chain settle window: counter loaded with the number of key cells
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    if (cfg_wr) settle_d = 4'(NumRounds);
    else if (settle_q != 4'd0) settle_d = settle_q - 4'd1;
    else settle_d = settle_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= 4'(NumRounds);
    end else begin
      settle_q <= settle_d;
    end
  end

  // chain moves when the last stage is empty or being taken
  assign adv          = !ctl[NumRounds].valid || out_if.ready;
  assign in_if.ready  = adv && (settle_q == 4'd0);

  always_comb begin
    blk = {in_if.block_upper, in_if.block_lower};
    if (in_if.action == ActEncrypt) data0_d = blk ^ rk[0];
    else data0_d = (swap ? edge_swap(blk) : blk) ^ rk[NumRounds];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q <= '0;
    end else if (adv) begin
      ctl0_q <= '{valid: in_if.valid && in_if.ready, action: action_e'(in_if.action),
                  swap: swap};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) data0_q <= data0_d;
  end

  assign ctl[0]  = ctl0_q;
  assign data[0] = data0_q;

  for (genvar r = 1; r <= NumRounds; r++) begin : g_round
    aes_round_cell #(.Round(r)) u_round (
      .clk_i, .rst_ni,
      .en_i      (adv),
      .ctl_i     (ctl[r-1]),
      .data_i    (data[r-1]),
      .key_enc_i (rk[r]),
      .key_dec_i (rk[NumRounds-r]),
      .ctl_o     (ctl[r]),
      .data_o    (data[r])
    );
  end

  assign out_if.valid        = ctl[NumRounds].valid;
  assign out_if.result_upper = data[NumRounds][127:64];
  assign out_if.result_lower = data[NumRounds][63:0];
endmodule
`default_nettype wire

[hdl/aes_checker.sv]
// ----------------------------------------------------------------------------
// aes_checker: port-level assertions for the cipher block
// Bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic pready
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_valid_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(out_valid)) else $error("result valid unknown");
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready) else $error("accept while stalled");
  a_pready: assert property (@(posedge clk_i) pready) else $error("pready low");
endmodule

bind aes128_block_cipher_with_swap aes_checker u_chk (
  .clk_i, .rst_ni,
  .in_ready (in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .pready
);
`default_nettype wire

[verif/aes128_block_cipher_with_swap_test.sv]
// ----------------------------------------------------------------------------
// aes128_block_cipher_with_swap_test: self-checking bench for the AES-128 block
// Drives random and directed blocks in both directions under several keys and
// swap settings, predicts each result with a local cipher model and compares
// every result transaction in order.
// ----------------------------------------------------------------------------
module aes128_block_cipher_with_swap_test;
  import aes_pkg::*;

  typedef struct {
    action_e     act;
    logic [63:0] hi;
    logic [63:0] lo;
  } blk_item_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
  } cipher_out_t;

  logic clk_i;
  logic rst_ni;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  aes_in_if  in_if ();
  aes_out_if out_if ();

  aes128_block_cipher_with_swap uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if.sink),
    .out_if  (out_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // local copy of the configuration, updated as each register write lands
  logic [63:0] cur_key_hi;
  logic [63:0] cur_key_lo;
  logic        cur_swap;

  blk_item_t   pending_blocks[$];
  cipher_out_t expected_results[$];
  int unsigned fail_count;
  int unsigned cycle_count;
  localparam int unsigned CycleLimit = 400000;

  // ---------------------------------------------------------------- predictor
  logic [7:0] fsb [256];
  logic [7:0] isb [256];

  function automatic logic [7:0] gmul2(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] v, input logic [7:0] f);
    logic [7:0] acc;
    acc = '0;
    for (int b = 0; b < 8; b++) begin
      if (f[b]) acc ^= v;
      v = gmul2(v);
    end
    return acc;
  endfunction

  // full AES-128 in byte arrays, byte 0 is the MSB of the upper word
  function automatic cipher_out_t aes_cipher(input blk_item_t it, input logic [63:0] khi,
                                             input logic [63:0] klo, input logic swp);
    logic [7:0] rk [176];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] w [4];
    logic [7:0] tmp;
    logic [7:0] rc;
    logic [7:0] acc;
    logic [7:0] fm [4];
    logic [7:0] im [4];
    int src;
    cipher_out_t res;
    fm = '{8'h02, 8'h03, 8'h01, 8'h01};
    im = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    for (int i = 0; i < 8; i++) begin
      rk[i]   = khi[63-8*i -: 8];
      rk[8+i] = klo[63-8*i -: 8];
      s[i]    = it.hi[63-8*i -: 8];
      s[8+i]  = it.lo[63-8*i -: 8];
    end
    rc = 8'h01;
    for (int p = 16; p < 176; p += 4) begin
      for (int a = 0; a < 4; a++) w[a] = rk[p-4+a];
      if (p % 16 == 0) begin
        tmp  = w[0];
        w[0] = fsb[w[1]] ^ rc;
        w[1] = fsb[w[2]];
        w[2] = fsb[w[3]];
        w[3] = fsb[tmp];
        rc   = gmul2(rc);
      end
      for (int a = 0; a < 4; a++) rk[p+a] = rk[p-16+a] ^ w[a];
    end
    if (it.act == ActDecrypt && swp) begin
      tmp = s[0]; s[0] = s[1]; s[1] = tmp;
      tmp = s[14]; s[14] = s[15]; s[15] = tmp;
    end
    // round sequence: r = 0 initial key add, rounds 1..10
    for (int r = 0; r <= 10; r++) begin
      int kr;
      kr = (it.act == ActEncrypt) ? r : 10 - r;
      if (r > 0) begin
        if (it.act == ActDecrypt && r > 1) begin
          // inverse mix sits after the key add of the previous round
          for (int c = 0; c < 4; c++)
            for (int rw = 0; rw < 4; rw++) begin
              acc = '0;
              for (int j = 0; j < 4; j++) acc ^= gmul(s[4*c+j], im[(j-rw+4)&3]);
              t[4*c+rw] = acc;
            end
          s = t;
        end
        for (int c = 0; c < 4; c++)
          for (int rw = 0; rw < 4; rw++) begin
            src = (it.act == ActEncrypt) ? ((c+rw)&3) : ((c-rw+4)&3);
            t[4*c+rw] = (it.act == ActEncrypt) ? fsb[s[4*src+rw]] : isb[s[4*src+rw]];
          end
        s = t;
        if (it.act == ActEncrypt && r < 10) begin
          for (int c = 0; c < 4; c++)
            for (int rw = 0; rw < 4; rw++) begin
              acc = '0;
              for (int j = 0; j < 4; j++) acc ^= gmul(s[4*c+j], fm[(j-rw+4)&3]);
              t[4*c+rw] = acc;
            end
          s = t;
        end
      end
      for (int i = 0; i < 16; i++) s[i] ^= rk[16*kr+i];
    end
    if (it.act == ActEncrypt && swp) begin
      tmp = s[0]; s[0] = s[1]; s[1] = tmp;
      tmp = s[14]; s[14] = s[15]; s[15] = tmp;
    end
    for (int i = 0; i < 8; i++) begin
      res.hi[63-8*i -: 8] = s[i];
      res.lo[63-8*i -: 8] = s[8+i];
    end
    return res;
  endfunction

  // S-box contents: forward table built from inverse in GF(2^8) plus affine map, inverse table from it
  initial begin
    logic [7:0] inv;
    logic [7:0] y;
    for (int a = 0; a < 256; a++) begin
      inv = 8'h00;
      for (int b = 1; b < 256; b++)
        if (gmul(a[7:0], b[7:0]) == 8'h01) inv = b[7:0];
      y = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
        ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      fsb[a] = y;
      isb[y] = a[7:0];
    end
  end

  // ---------------------------------------------------------------- clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // when set, blocks feeding while the config port is being used; this bench keeps it low
  logic in_gap_hold;

  // ---------------------------------------------------------------- driver
  int unsigned in_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid       <= 1'b0;
      in_if.action      <= ActEncrypt;
      in_if.block_upper <= '0;
      in_if.block_lower <= '0;
      in_gap            <= 0;
    end else begin
      blk_item_t   nxt;
      int unsigned gap;
      gap = in_gap;
      if (in_if.valid && in_if.ready) begin
        expected_results.push_back(aes_cipher(pending_blocks.pop_front(),
                                              cur_key_hi, cur_key_lo, cur_swap));
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap > 0) begin
          in_gap      <= gap - 1;
          in_if.valid <= 1'b0;
        end else if (pending_blocks.size() > 0 && !in_gap_hold) begin
          nxt = pending_blocks[0];
          in_gap            <= 0;
          in_if.valid       <= 1'b1;
          in_if.action      <= nxt.act;
          in_if.block_upper <= nxt.hi;
          in_if.block_lower <= nxt.lo;
        end else begin
          in_gap      <= 0;
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  int unsigned out_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_gap      <= 0;
    end else begin
      cipher_out_t want;
      int unsigned errs;
      int unsigned gap;
      errs = 0;
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transaction %h_%h", $time,
                   out_if.result_upper, out_if.result_lower);
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (want.hi !== out_if.result_upper) begin
            $display("%0t: result_upper expected %h actual %h", $time, want.hi,
                     out_if.result_upper);
            errs++;
          end
          if (want.lo !== out_if.result_lower) begin
            $display("%0t: result_lower expected %h actual %h", $time, want.lo,
                     out_if.result_lower);
            errs++;
          end
        end
        if (errs != 0) fail_count <= fail_count + errs;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
          out_gap      <= gap - 1;
          out_if.ready <= 1'b0;
        end else begin
          out_if.ready <= 1'b1;
        end
      end else if (out_gap > 0) begin
        out_gap      <= out_gap - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- config
  task automatic reg_write(input logic [4:0] addr, input logic [63:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == AddrKeyUpper) cur_key_hi = val;
    else if (addr == AddrKeyLower) cur_key_lo = val;
    else if (addr == AddrSwapEnable) cur_swap = val[0];
  endtask

  // wait for the pipe to drain before touching a register
  task automatic drain_pipe();
    while (pending_blocks.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic add_block(input action_e a, input logic [63:0] h, input logic [63:0] l);
    blk_item_t it;
    it.act = a;
    it.hi  = h;
    it.lo  = l;
    pending_blocks.push_back(it);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // a phase: random blocks, some encrypt blocks followed by a round trip decrypt of their ciphertext
  task automatic random_phase(input int unsigned n);
    blk_item_t it;
    cipher_out_t ct;
    for (int i = 0; i < n; i++) begin
      it.act = $urandom_range(0, 1) ? ActDecrypt : ActEncrypt;
      it.hi  = rand64();
      it.lo  = rand64();
      if ($urandom_range(0, 7) == 0) it.hi = $urandom_range(0, 1) ? '0 : '1;
      if ($urandom_range(0, 7) == 0) it.lo = $urandom_range(0, 1) ? '0 : '1;
      pending_blocks.push_back(it);
      if (it.act == ActEncrypt && $urandom_range(0, 1)) begin
        ct = aes_cipher(it, cur_key_hi, cur_key_lo, cur_swap);
        add_block(ActDecrypt, ct.hi, ct.lo);
        i++;
      end
    end
    drain_pipe();
  endtask

  initial begin
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_gap_hold = 1'b0;
    cur_key_hi = '0; cur_key_lo = '0; cur_swap = 1'b1;
    fail_count = 0; cycle_count = 0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset key (all zero) with swap on
    add_block(ActEncrypt, '0, '0);
    add_block(ActDecrypt, '0, '0);
    add_block(ActEncrypt, '1, '1);
    drain_pipe();

    // FIPS-197 appendix vector, plain AES
    reg_write(AddrSwapEnable, 64'h0);
    reg_write(AddrKeyUpper, 64'h0001020304050607);
    reg_write(AddrKeyLower, 64'h08090a0b0c0d0e0f);
    add_block(ActEncrypt, 64'h0011223344556677, 64'h8899aabbccddeeff);
    add_block(ActDecrypt, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    add_block(ActEncrypt, '1, '0);
    add_block(ActDecrypt, '0, '1);
    drain_pipe();

    // same key with the edge swap
    reg_write(AddrSwapEnable, 64'hffff_fffe_0000_0001);
    add_block(ActEncrypt, 64'h0011223344556677, 64'h8899aabbccddeeff);
    add_block(ActDecrypt, 64'hc469e0d86a7b0430, 64'hd8cdb78070b45ac5);
    add_block(ActEncrypt, 64'h8000000000000001, 64'h8000000000000001);
    drain_pipe();

    // all ones key
    reg_write(AddrKeyUpper, '1);
    reg_write(AddrKeyLower, '1);
    add_block(ActEncrypt, '0, '0);
    add_block(ActDecrypt, '1, '1);
    drain_pipe();

    // random phases across key and swap settings
    for (int ph = 0; ph < 8; ph++) begin
      reg_write(AddrKeyUpper, rand64());
      reg_write(AddrKeyLower, rand64());
      reg_write(AddrSwapEnable, {63'h0, ph[0]});
      random_phase(135);
    end
    drain_pipe();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
